@@ rtl/hsl_to_rgb_converter_assert.svh @@
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// check b in the same cycle as a
`define H2R_ASSERT_NOW(label, clk_sig, rst_sig, a, b) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (a) |-> (b)) \
		else $error("same-cycle implication failed");

// check b a fixed number of cycles after a
`define H2R_ASSERT_AFTER(label, clk_sig, rst_sig, a, n, b) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (a) |-> ##n (b)) \
		else $error("delayed implication failed");

`endif

@@ rtl/h2r_pkg.sv @@
package h2r_pkg;

	localparam int HUE_BITS    = 13;
	localparam int WEIGHT_BITS = 10;
	localparam int POS_BITS    = 11;
	localparam int SECTOR_BITS = 3;
	localparam int RAW_BITS    = 4;
	localparam int RECIP_SHIFT = 32;

	localparam logic [HUE_BITS-1:0] SECTOR_SPAN = 13'd960;
	localparam logic [HUE_BITS-1:0] PAIR_SPAN   = 13'd1920;

	// floor(2^32 / 15)
	localparam logic [RECIP_SHIFT-1:0] RECIP_15 = 32'd286331153;

	localparam logic [SECTOR_BITS-1:0] SEC_RED_YELLOW    = 3'd0;
	localparam logic [SECTOR_BITS-1:0] SEC_YELLOW_GREEN  = 3'd1;
	localparam logic [SECTOR_BITS-1:0] SEC_GREEN_CYAN    = 3'd2;
	localparam logic [SECTOR_BITS-1:0] SEC_CYAN_BLUE     = 3'd3;
	localparam logic [SECTOR_BITS-1:0] SEC_BLUE_MAGENTA  = 3'd4;
	localparam logic [SECTOR_BITS-1:0] SEC_MAGENTA_RED   = 3'd5;

endpackage

@@ rtl/hsl_to_rgb_converter.sv @@
// HSL to RGB color converter.
// Input transaction: hue_sixteenths (1/16 degree), saturation and lightness
// (unsigned fractions of COMPONENT_BITS bits), accepted at a rising edge with
// start high and busy low. busy is always low: a transaction may be started
// in every cycle.
// Result transaction: red, green, blue, valid for exactly the one cycle in
// which done is high; the receiver cannot stall and needs none.
// Throughput: one color per cycle, set by the six-stage pipeline
// (stage 1 chroma terms and hue sector, stage 2 chroma multiply, stage 3
// secondary multiply, stage 4 reciprocal multiply for the divide by 960,
// stage 5 quotient correction, stage 6 sector placement, offset, saturation).
// Hue codes above 5759 wrap around the color wheel.
// Reset (arst_n low) clears the stage valid bits: transactions in flight are
// dropped and done stays low until new transactions drain through.
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [h2r_pkg::HUE_BITS-1:0]         hue_sixteenths,
	input  logic [COMPONENT_BITS-1:0]            saturation,
	input  logic [COMPONENT_BITS-1:0]            lightness,
	output logic                                 done,
	output logic [COMPONENT_BITS-1:0]            red,
	output logic [COMPONENT_BITS-1:0]            green,
	output logic [COMPONENT_BITS-1:0]            blue
);

	import h2r_pkg::*;

	localparam int B  = COMPONENT_BITS;
	localparam int PW = B + WEIGHT_BITS;
	localparam int QW = PW - 6;
	localparam int TW = B + 2;

	localparam logic [B:0]    ONE_C  = {1'b1, {B{1'b0}}};
	localparam logic [TW-1:0] MAX_C  = {2'b00, {B{1'b1}}};

	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [B:0]       onemd_s1;
	logic [B-1:0]     sat_s1;
	logic [B:0]       light2_s1;
	logic [WEIGHT_BITS-1:0] weight_s1;
	logic [SECTOR_BITS-1:0] sector_s1;

	logic [B-1:0]     chroma_s2;
	logic [B:0]       light2_s2;
	logic [WEIGHT_BITS-1:0] weight_s2;
	logic [SECTOR_BITS-1:0] sector_s2;

	logic [PW-1:0]    prod_s3;
	logic [B-1:0]     chroma_s3;
	logic [B:0]       light2_s3;
	logic [SECTOR_BITS-1:0] sector_s3;

	logic [QW-1:0]    q_s4;
	logic [B-1:0]     est_s4;
	logic [B-1:0]     chroma_s4;
	logic [B:0]       light2_s4;
	logic [SECTOR_BITS-1:0] sector_s4;

	logic [B-1:0]     x_s5;
	logic [B-1:0]     chroma_s5;
	logic [B:0]       light2_s5;
	logic [SECTOR_BITS-1:0] sector_s5;

	logic [B-1:0]     red_s6, green_s6, blue_s6;

	logic [B:0]       light2_c, dist_c, onemd_c;
	logic [RAW_BITS-1:0] raw_c;
	logic [SECTOR_BITS-1:0] sector_c;
	logic [HUE_BITS-1:0] base_c, pos_full_c;
	logic [POS_BITS-1:0] pos_c;
	logic [WEIGHT_BITS-1:0] off_c, weight_c;
	logic [2*B:0]     chroma_full_c;
	logic [PW-1:0]    prod_c;
	logic [QW-1:0]    q_c;
	logic [QW+RECIP_SHIFT-1:0] est_full_c;
	logic [QW-1:0]    est15_c, rem_c;
	logic [B-1:0]     x_c;
	logic [B-1:0]     part_r_c, part_g_c, part_b_c;

	function automatic logic [B-1:0] finish_f(
		input logic [B:0]   light2,
		input logic [B-1:0] chroma,
		input logic [B-1:0] part
	);
		logic [TW-1:0] top;
		logic [TW-1:0] diff;
		logic [TW-1:0] half;
		top  = {1'b0, light2} + {1'b0, part, 1'b0};
		diff = top - {2'b00, chroma};
		half = {1'b0, diff[TW-1:1]};
		if (top < {2'b00, chroma}) begin
			finish_f = '0;
		end else if (half > MAX_C) begin
			finish_f = MAX_C[B-1:0];
		end else begin
			finish_f = half[B-1:0];
		end
	endfunction

	assign busy = 1'b0;

	always_comb begin
		light2_c = {lightness, 1'b0};
		dist_c   = (light2_c >= ONE_C) ? (light2_c - ONE_C) : (ONE_C - light2_c);
		onemd_c  = ONE_C - dist_c;
		raw_c    = '0;
		for (int k = 1; k <= 8; k++) begin
			if (hue_sixteenths >= HUE_BITS'(k * 960))
				raw_c = raw_c + RAW_BITS'(1);
		end
		sector_c = (raw_c >= RAW_BITS'(6)) ? SECTOR_BITS'(raw_c - RAW_BITS'(6))
			: raw_c[SECTOR_BITS-1:0];
		base_c = '0;
		for (int k = 1; k <= 4; k++) begin
			if (hue_sixteenths >= HUE_BITS'(k * 1920))
				base_c = HUE_BITS'(k * 1920);
		end
		pos_full_c = hue_sixteenths - base_c;
		pos_c      = pos_full_c[POS_BITS-1:0];
		off_c      = (pos_c >= POS_BITS'(SECTOR_SPAN))
			? WEIGHT_BITS'(pos_c - POS_BITS'(SECTOR_SPAN))
			: WEIGHT_BITS'(POS_BITS'(SECTOR_SPAN) - pos_c);
		weight_c   = WEIGHT_BITS'(SECTOR_SPAN) - off_c;
	end

	assign chroma_full_c = {{B{1'b0}}, onemd_s1} * {{(B+1){1'b0}}, sat_s1};
	assign prod_c        = {{WEIGHT_BITS{1'b0}}, chroma_s2} * {{B{1'b0}}, weight_s2};
	assign q_c           = prod_s3[PW-1:6];
	assign est_full_c    = {{RECIP_SHIFT{1'b0}}, q_c} * {{QW{1'b0}}, RECIP_15};
	assign est15_c       = {est_s4, 4'b0000} - {4'b0000, est_s4};
	assign rem_c         = q_s4 - est15_c;
	assign x_c           = (rem_c >= QW'(15)) ? (est_s4 + B'(1)) : est_s4;

	always_comb begin
		part_r_c = '0;
		part_g_c = '0;
		part_b_c = '0;
		case (sector_s5)
			SEC_RED_YELLOW: begin
				part_r_c = chroma_s5;
				part_g_c = x_s5;
			end
			SEC_YELLOW_GREEN: begin
				part_r_c = x_s5;
				part_g_c = chroma_s5;
			end
			SEC_GREEN_CYAN: begin
				part_g_c = chroma_s5;
				part_b_c = x_s5;
			end
			SEC_CYAN_BLUE: begin
				part_g_c = x_s5;
				part_b_c = chroma_s5;
			end
			SEC_BLUE_MAGENTA: begin
				part_r_c = x_s5;
				part_b_c = chroma_s5;
			end
			default: begin
				part_r_c = chroma_s5;
				part_b_c = x_s5;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		onemd_s1  <= onemd_c;
		sat_s1    <= saturation;
		light2_s1 <= light2_c;
		weight_s1 <= weight_c;
		sector_s1 <= sector_c;

		chroma_s2 <= chroma_full_c[B +: B];
		light2_s2 <= light2_s1;
		weight_s2 <= weight_s1;
		sector_s2 <= sector_s1;

		prod_s3   <= prod_c;
		chroma_s3 <= chroma_s2;
		light2_s3 <= light2_s2;
		sector_s3 <= sector_s2;

		q_s4      <= q_c;
		est_s4    <= est_full_c[RECIP_SHIFT +: B];
		chroma_s4 <= chroma_s3;
		light2_s4 <= light2_s3;
		sector_s4 <= sector_s3;

		x_s5      <= x_c;
		chroma_s5 <= chroma_s4;
		light2_s5 <= light2_s4;
		sector_s5 <= sector_s4;

		red_s6    <= finish_f(light2_s5, chroma_s5, part_r_c);
		green_s6  <= finish_f(light2_s5, chroma_s5, part_g_c);
		blue_s6   <= finish_f(light2_s5, chroma_s5, part_b_c);
	end

	assign done  = v_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	`H2R_ASSERT_AFTER(a_latency, clk, arst_n, start, 6, done)
	`H2R_ASSERT_AFTER(a_no_spurious, clk, arst_n, !start, 6, !done)
	`H2R_ASSERT_AFTER(a_gray, clk, arst_n, start && (saturation == '0), 6,
		(red == green) && (green == blue))
	`H2R_ASSERT_NOW(a_x_bound, clk, arst_n, v_s5, x_s5 <= chroma_s5)

endmodule
